### sv/c_comment_and_literal_stripper_core_macros.svh
// Assertion macros shared by the stripper RTL.
`ifndef C_COMMENT_AND_LITERAL_STRIPPER_CORE_MACROS_SVH
`define C_COMMENT_AND_LITERAL_STRIPPER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clk while out of reset.
`define CSLS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stripper assertion failed");

// Next-cycle implication, checked at every rising clk while out of reset.
`define CSLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stripper assertion failed");

`endif

### sv/csls_pkg.sv
// Shared types and constants for the C comment and literal stripper.
`timescale 1ns / 1ps
package csls_pkg;

  typedef logic [7:0] char_t;

  // Lexer modes; code 7 is unused and behaves as normal text.
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_SLASH   = 3'd1,
    MODE_LINE    = 3'd2,
    MODE_BLOCK   = 3'd3,
    MODE_STAR    = 3'd4,
    MODE_LIT     = 3'd5,
    MODE_LIT_ESC = 3'd6
  } mode_t;

  localparam char_t CH_NL    = 8'h0A;
  localparam char_t CH_SLASH = 8'h2F;
  localparam char_t CH_STAR  = 8'h2A;
  localparam char_t CH_DQ    = 8'h22;
  localparam char_t CH_SQ    = 8'h27;
  localparam char_t CH_BSL   = 8'h5C;

  // Result queue; depth must be a power of two so pointers wrap naturally.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // Results of one byte step: zero, one or two bytes.
  typedef struct packed {
    logic [1:0] cnt;
    char_t      byte0;
    char_t      byte1;
  } res_t;

  // Lexer state as seen from outside.
  typedef struct packed {
    mode_t mode;
    logic  line_has_output;
  } lex_stat_t;

  // One queued result.
  typedef struct packed {
    char_t data;
    logic  last;
  } entry_t;

endpackage

### sv/csls_lexer.sv
// Lexer state and the per-byte step logic of the stripper.
`timescale 1ns / 1ps
module csls_lexer import csls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  char_t     cur_byte,
  input  logic      cur_last,
  output res_t      res,
  output lex_stat_t stat
);

  mode_t mode_r, mode_nxt;
  logic  quote_r, quote_nxt;
  logic  lho_r, lho_nxt;

  // Shared decode
  logic  is_nl, is_slash, is_star, is_dq, is_sq, is_bsl, is_quote;
  logic  pre_slash, eff_normal, lho_eff;
  logic  main_vld;
  char_t main_byte;

  always_comb begin
    is_nl     = (cur_byte == CH_NL);
    is_slash  = (cur_byte == CH_SLASH);
    is_star   = (cur_byte == CH_STAR);
    is_dq     = (cur_byte == CH_DQ);
    is_sq     = (cur_byte == CH_SQ);
    is_bsl    = (cur_byte == CH_BSL);
    is_quote  = quote_r ? is_sq : is_dq;
    // held slash not followed by a comment opener: slash goes out first
    pre_slash = (mode_r == MODE_SLASH) && !is_slash && !is_star;
    eff_normal = pre_slash || (mode_r == MODE_NORMAL) || (mode_r == 3'd7);
    lho_eff   = pre_slash | lho_r;
  end

  // Next state
  always_comb begin
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    lho_nxt   = lho_r;
    if (eff_normal) begin
      lho_nxt  = lho_eff;
      mode_nxt = MODE_NORMAL;
      if (is_nl) begin
        lho_nxt = 1'b0;
      end else if (is_slash) begin
        mode_nxt = MODE_SLASH;
      end else if (is_dq || is_sq) begin
        mode_nxt  = MODE_LIT;
        quote_nxt = is_sq;
      end else begin
        lho_nxt = 1'b1;
      end
    end else begin
      case (mode_r)
        MODE_SLASH: begin
          mode_nxt = is_slash ? MODE_LINE : MODE_BLOCK;
        end
        MODE_LINE: begin
          if (is_nl) begin
            mode_nxt = MODE_NORMAL;
            lho_nxt  = 1'b0;
          end
        end
        MODE_BLOCK: begin
          if (is_star) begin
            mode_nxt = MODE_STAR;
          end else if (is_nl) begin
            lho_nxt = 1'b0;
          end
        end
        MODE_STAR: begin
          if (is_slash) begin
            mode_nxt = MODE_NORMAL;
          end else if (!is_star) begin
            mode_nxt = MODE_BLOCK;
            if (is_nl) lho_nxt = 1'b0;
          end
        end
        MODE_LIT: begin
          if (is_nl) begin
            mode_nxt = MODE_NORMAL;
            lho_nxt  = 1'b0;
          end else if (is_bsl) begin
            mode_nxt = MODE_LIT_ESC;
          end else if (is_quote) begin
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_LIT_ESC: begin
          if (is_nl) begin
            mode_nxt = MODE_NORMAL;
            lho_nxt  = 1'b0;
          end else begin
            mode_nxt = MODE_LIT;
          end
        end
        default: begin
          mode_nxt = MODE_NORMAL;
        end
      endcase
    end
    // end of text returns everything to reset
    if (cur_last) begin
      mode_nxt  = MODE_NORMAL;
      quote_nxt = 1'b0;
      lho_nxt   = 1'b0;
    end
  end

  // Outputs: optional flushed slash, then at most one main byte
  always_comb begin
    main_vld  = 1'b0;
    main_byte = cur_byte;
    if (eff_normal) begin
      if (is_nl) begin
        main_vld = lho_eff;
      end else if (is_slash) begin
        main_vld = cur_last;
      end else if (!is_dq && !is_sq) begin
        main_vld = 1'b1;
      end
    end else begin
      main_vld = is_nl && lho_r && (mode_r != MODE_SLASH);
    end
    res.cnt   = {1'b0, pre_slash} + {1'b0, main_vld};
    res.byte0 = pre_slash ? CH_SLASH : main_byte;
    res.byte1 = main_byte;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      quote_r <= 1'b0;
      lho_r   <= 1'b0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      lho_r   <= lho_nxt;
    end
  end

  assign stat.mode            = mode_r;
  assign stat.line_has_output = lho_r;

endmodule

### sv/csls_res_fifo.sv
// Small result queue taking up to two bytes per cycle and giving one while out_stall is low.
`timescale 1ns / 1ps
module csls_res_fifo import csls_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  res_t               res,
  output logic               room,
  output logic [FIFO_CW-1:0] level,
  output logic               out_valid,
  input  logic               out_stall,
  output char_t              out_byte,
  output logic               out_run_end
);

  entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic [1:0]         push_cnt;
  logic               pop;

  // Room for a worst-case push, judged from registered count only
  assign room = (count_r <= FIFO_CW'(FIFO_DEPTH - 2));

  always_comb begin
    push_cnt   = push ? res.cnt : 2'd0;
    pop        = (count_r != '0) && !out_stall;
    count_nxt  = count_r + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry writes; the last entry of a step carries the run-end flag
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= '{data: res.byte0, last: (push_cnt == 2'd1)};
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_r + FIFO_AW'(1)] <= '{data: res.byte1, last: 1'b1};
    end
  end

  assign level       = count_r;
  assign out_valid   = (count_r != '0);
  assign out_byte    = mem_r[rd_ptr_r].data;
  assign out_run_end = mem_r[rd_ptr_r].last;

endmodule

### sv/c_comment_and_literal_stripper_core.sv
// Top level of the C comment and literal stripper.
//
// Usage: source text enters one byte per transaction on in_byte, with
// in_text_end high on the final byte of the text. Kept bytes leave on
// out_byte; out_run_end marks the last result caused by an input byte.
// Bytes inside comments and quoted literals are removed along with the
// quotes, and a newline is passed only for a line that kept a byte.
// Both channels use valid/stall; a transaction happens on a rising clk
// edge with valid high and stall low.
// Results of a taken byte pass the input register and the result queue.
// Throughput: one byte per cycle while each yields at most one result
// and out_stall stays low; a byte that flushes a held slash gives two
// results, drained by the single output port of a 4-entry result queue.
// in_stall rises only when the queue cannot take a worst-case pair.
// Reset (rst_n low, synchronous) empties the queue and input register and
// returns the lexer to normal text on a fresh line.
// When the receiver stalls, out_* hold and the queue fills, then input
// transactions stop until space returns.
`timescale 1ns / 1ps
`include "c_comment_and_literal_stripper_core_macros.svh"
module c_comment_and_literal_stripper_core import csls_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  char_t in_byte,
  input  logic  in_text_end,
  output logic  out_valid,
  input  logic  out_stall,
  output char_t out_byte,
  output logic  out_run_end
);

  logic               s1_valid_r;
  char_t              s1_byte_r;
  logic               s1_last_r;
  logic               room;
  logic               step;
  logic [FIFO_CW-1:0] level;
  res_t               res;
  lex_stat_t          stat;

  // Held byte moves into the lexer when the queue has room
  assign step     = s1_valid_r && room;
  assign in_stall = s1_valid_r && !room;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_text_end;
    end
  end

  csls_lexer u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .cur_byte (s1_byte_r),
    .cur_last (s1_last_r),
    .res      (res),
    .stat     (stat)
  );

  csls_res_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (step),
    .res         (res),
    .room        (room),
    .level       (level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_run_end (out_run_end)
  );

  // Checks
  `CSLS_ASSERT_NOW(a_fifo_bound, 1'b1, level <= FIFO_CW'(FIFO_DEPTH))
  `CSLS_ASSERT_NOW(a_push_room, step, level <= FIFO_CW'(FIFO_DEPTH - 2))
  `CSLS_ASSERT_NEXT(a_end_resets, step && s1_last_r,
    stat.mode == MODE_NORMAL && !stat.line_has_output)
  `CSLS_ASSERT_NOW(a_slash_flush, step && s1_last_r && stat.mode == MODE_SLASH &&
    s1_byte_r != CH_SLASH && s1_byte_r != CH_STAR, res.cnt != 2'd0)

endmodule

### tb/sv/c_comment_and_literal_stripper_core_test.sv
// Self-checking testbench for the C comment and literal stripper core.
`timescale 1ns / 1ps
module c_comment_and_literal_stripper_core_test;
  import csls_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PLAIN_ITEMS  = 1100;
  localparam int MAX_WAIT     = 19;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AFTER   = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRINT_CAP    = 200;

  logic  clk         = 1'b0;
  logic  rst_n       = 1'b0;
  logic  in_valid    = 1'b0;
  logic  in_stall;
  char_t in_byte     = 8'h00;
  logic  in_text_end = 1'b0;
  logic  out_valid;
  logic  out_stall   = 1'b0;
  char_t out_byte;
  logic  out_run_end;

  c_comment_and_literal_stripper_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_text_end (in_text_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_run_end (out_run_end)
  );

  always #1 clk = ~clk;

  // Source bytes waiting to be sent and stripped bytes still owed by the block
  entry_t pending_bytes[$];
  entry_t expected_chars[$];
  int     total_items    = 0;
  int     accepted_count = 0;
  int     results_seen   = 0;
  int     mismatch_count = 0;
  int     cycle_count    = 0;

  // Shadow lexer state
  mode_t  lex_mode     = MODE_NORMAL;
  logic   quote_single = 1'b0;
  logic   line_kept    = 1'b0;
  char_t  step_bytes[$];

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH %s: got %02h want %02h (result %0d, t=%0t)",
               what, got, want, results_seen, $realtime);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------
  // Stripper prediction
  // ---------------------------------------------------------------------
  function automatic void reset_lexer();
    lex_mode     = MODE_NORMAL;
    quote_single = 1'b0;
    line_kept    = 1'b0;
  endfunction

  // At most two results per input byte
  function automatic void put_char(char_t c);
    if (step_bytes.size() < 2)
      step_bytes.push_back(c);
  endfunction

  function automatic void keep_char(char_t c);
    put_char(c);
    line_kept = 1'b1;
  endfunction

  // Newline passes only for a line that kept something
  function automatic void close_line();
    if (line_kept)
      put_char(CH_NL);
    line_kept = 1'b0;
  endfunction

  function automatic void plain_char(char_t c);
    lex_mode = MODE_NORMAL;
    if (c == CH_NL) begin
      close_line();
    end else if (c == CH_SLASH) begin
      lex_mode = MODE_SLASH;
    end else if (c == CH_DQ) begin
      lex_mode     = MODE_LIT;
      quote_single = 1'b0;
    end else if (c == CH_SQ) begin
      lex_mode     = MODE_LIT;
      quote_single = 1'b1;
    end else begin
      keep_char(c);
    end
  endfunction

  function automatic void strip_step(char_t c, logic text_last);
    char_t  closer;
    entry_t res;
    step_bytes.delete();
    case (lex_mode)
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          lex_mode = MODE_LINE;
        end else if (c == CH_STAR) begin
          lex_mode = MODE_BLOCK;
        end else begin
          // held slash was not a comment opener
          keep_char(CH_SLASH);
          plain_char(c);
        end
      end
      MODE_LINE: begin
        if (c == CH_NL) begin
          lex_mode = MODE_NORMAL;
          close_line();
        end
      end
      MODE_BLOCK: begin
        if (c == CH_STAR)
          lex_mode = MODE_STAR;
        else if (c == CH_NL)
          close_line();
      end
      MODE_STAR: begin
        if (c == CH_SLASH) begin
          lex_mode = MODE_NORMAL;
        end else if (c != CH_STAR) begin
          lex_mode = MODE_BLOCK;
          if (c == CH_NL)
            close_line();
        end
      end
      MODE_LIT: begin
        closer = quote_single ? CH_SQ : CH_DQ;
        if (c == CH_NL) begin
          lex_mode = MODE_NORMAL;
          close_line();
        end else if (c == CH_BSL) begin
          lex_mode = MODE_LIT_ESC;
        end else if (c == closer) begin
          lex_mode = MODE_NORMAL;
        end
      end
      MODE_LIT_ESC: begin
        if (c == CH_NL) begin
          lex_mode = MODE_NORMAL;
          close_line();
        end else begin
          lex_mode = MODE_LIT;
        end
      end
      default: plain_char(c);
    endcase
    // end of text flushes a held slash and restarts the lexer
    if (text_last) begin
      if (lex_mode == MODE_SLASH)
        put_char(CH_SLASH);
      reset_lexer();
    end
    foreach (step_bytes[i]) begin
      res.data = step_bytes[i];
      res.last = (i == step_bytes.size() - 1);
      expected_chars.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------
  task automatic add_item(char_t c, logic last);
    entry_t item;
    item.data = c;
    item.last = last;
    pending_bytes.push_back(item);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++)
      add_item(char_t'(s[i]), 1'b0);
  endtask

  function automatic char_t any_byte();
    return char_t'($urandom_range(0, 255));
  endfunction

  function automatic char_t printable_byte();
    return char_t'($urandom_range(32, 126));
  endfunction

  // Comment bodies lean on stars, slashes and newlines
  function automatic char_t comment_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return CH_STAR;
    if (pick < 40) return CH_NL;
    if (pick < 50) return CH_SLASH;
    return any_byte();
  endfunction

  // Literal bodies lean on escapes and quotes of both kinds
  function automatic char_t literal_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return CH_BSL;
    if (pick < 30) return CH_DQ;
    if (pick < 40) return CH_SQ;
    if (pick < 43) return CH_NL;
    return printable_byte();
  endfunction

  task automatic build_stimulus();
    int    pick;
    char_t quote;

    // directed: kept line, dropped empty line, whitespace, slash then byte
    add_text("a\n\n /x\n");
    // line comment, block comment with slash right after its star, star run
    add_text("//c\nk/*/\n**/");
    // literals close only on their own quote; backslash then newline
    add_text("'\"'\"\\\"'\\\n");
    // held slash at end of text, byte extremes
    add_item(CH_SLASH, 1'b1);
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b1);

    // random C-like token stream with noise mixed in
    while (pending_bytes.size() < PLAIN_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        repeat ($urandom_range(1, 6)) begin
          add_item(char_t'(8'h61 + $urandom_range(0, 25)), 1'b0);
        end
      end else if (pick < 45) begin
        add_item(CH_NL, 1'b0);
      end else if (pick < 55) begin
        add_item(CH_SLASH, 1'b0);
        add_item(CH_SLASH, 1'b0);
        repeat ($urandom_range(0, 8)) add_item(any_byte(), 1'b0);
        add_item(CH_NL, 1'b0);
      end else if (pick < 65) begin
        add_item(CH_SLASH, 1'b0);
        add_item(CH_STAR, 1'b0);
        repeat ($urandom_range(0, 8)) add_item(comment_byte(), 1'b0);
        if ($urandom_range(0, 1) == 0)
          add_item(CH_STAR, 1'b0);
        add_item(CH_STAR, 1'b0);
        add_item(CH_SLASH, 1'b0);
      end else if (pick < 77) begin
        quote = ($urandom_range(0, 1) == 0) ? CH_DQ : CH_SQ;
        add_item(quote, 1'b0);
        repeat ($urandom_range(0, 6)) add_item(literal_byte(), 1'b0);
        // some literals run to the end of the line unterminated
        if ($urandom_range(0, 9) == 0)
          add_item(CH_NL, 1'b0);
        else
          add_item(quote, 1'b0);
      end else if (pick < 85) begin
        add_item(CH_SLASH, 1'b0);
        add_item(printable_byte(), 1'b0);
      end else if (pick < 95) begin
        add_item(any_byte(), 1'b0);
      end else if (pick < 98) begin
        add_item(($urandom_range(0, 1) == 0) ? CH_SLASH : any_byte(), 1'b1);
      end else begin
        add_item(CH_STAR, 1'b0);
        add_item(CH_SLASH, 1'b0);
      end
    end
    total_items = pending_bytes.size();
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers queued bytes, predicts on each accepted transaction
  // ---------------------------------------------------------------------
  int     send_wait = 0;
  logic   send_calm = 1'b0;
  logic   send_free;
  entry_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
      reset_lexer();
    end else begin
      send_free = !in_valid;
      if (in_valid && !in_stall) begin
        strip_step(in_byte, in_text_end);
        accepted_count++;
        send_wait = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 63) == 0)
          send_calm = !send_calm;
        send_free = 1'b1;
      end
      if (send_free) begin
        if (send_wait > 0 || pending_bytes.size() == 0) begin
          if (send_wait > 0)
            send_wait--;
          in_valid <= 1'b0;
        end else begin
          next_item = pending_bytes.pop_front();
          in_valid    <= 1'b1;
          in_byte     <= next_item.data;
          in_text_end <= next_item.last;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Long receiver hold-off so the result queue fills and the input stalls
  // ---------------------------------------------------------------------
  int   hold_left  = 0;
  logic hold_fired = 1'b0;
  logic hold_on    = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_on <= 1'b0;
    end else begin
      if (!hold_fired && results_seen >= HOLD_AFTER) begin
        hold_fired = 1'b1;
        hold_left  = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      hold_on <= (hold_left > 0);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each result transaction, draws receiver stalls
  // ---------------------------------------------------------------------
  int     recv_wait = 0;
  logic   recv_calm = 1'b0;
  entry_t want_res;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("result with none pending", out_byte, 0);
        end else begin
          want_res = expected_chars.pop_front();
          if (out_byte !== want_res.data)
            report_mismatch("out_byte", out_byte, want_res.data);
          if (out_run_end !== want_res.last)
            report_mismatch("out_run_end", out_run_end, want_res.last);
        end
        results_seen <= results_seen + 1;
        recv_wait = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 63) == 0)
          recv_calm = !recv_calm;
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait > 0) || hold_on;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Reset, then wait for every byte to go in and every result to come out
  initial begin
    build_stimulus();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_count < total_items || expected_chars.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
